// ----- rtl/sktab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktab_pkg
// Shared types and constants of the session key table.
// ----------------------------------------------------------------------------
package sktab_pkg;

  localparam int IN_W  = 296;
  localparam int OUT_W = 128;

  localparam logic [31:0] TTL_RESET = 32'd3600;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [31:0] stamp;
    logic [7:0]  service;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } entry_t;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic match_found;
    logic free_found;
  } scan_flags_t;

endpackage

// ----- rtl/sktab_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktab_scan
// Shared compare unit: one entry per step, tracks first match, first free
// entry and lowest-index oldest entry.
// ----------------------------------------------------------------------------
module sktab_scan
  import sktab_pkg::*;
#(
  parameter int ENTRIES = 128,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           entry,
  input  logic [7:0]       service,
  input  logic [63:0]      key_high,
  input  logic [63:0]      key_low,
  output scan_flags_t      flags,
  output logic [IDX_W-1:0] match_idx,
  output logic [IDX_W-1:0] free_idx,
  output logic [IDX_W-1:0] oldest_idx,
  output entry_t           match_entry
);

  logic [31:0] oldest_stamp;
  logic        key_eq;
  logic        older;

  assign key_eq = entry.valid && (entry.service == service) &&
                  (entry.key_high == key_high) && (entry.key_low == key_low);
  assign older  = (idx == '0) || (entry.stamp < oldest_stamp);

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      flags <= '0;
    end else if (ctl.step) begin
      if (key_eq && !flags.match_found) begin
        flags.match_found <= 1'b1;
      end
      if (!entry.valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (key_eq && !flags.match_found) begin
        match_idx   <= idx;
        match_entry <= entry;
      end
      if (!entry.valid && !flags.free_found) begin
        free_idx <= idx;
      end
      if (entry.valid && older) begin
        oldest_idx   <= idx;
        oldest_stamp <= entry.stamp;
      end
    end
  end

endmodule

// ----- rtl/session_key_table_with_expiry_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_key_table_with_expiry_unit
// Session table keyed by service and 16-byte id, with put, get and delete
// and expiry of looked-up entries older than ttl_seconds.
// ----------------------------------------------------------------------------
// requests: one at a time; the next input transfer waits for the scan that reads
//   one table entry per cycle through the single memory read port
// reset: a clearing pass invalidates all entries; no input
//   transfer is taken meanwhile, ttl_seconds returns to 3600
// ----------------------------------------------------------------------------
module session_key_table_with_expiry_unit
  import sktab_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // service, sid_high, sid_low, addr_high, addr_low, now
  input  logic [1:0]       s_tuser,   // operation
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // found_addr_high, found_addr_low
  output logic             m_tuser,   // hit
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  function automatic logic [127:0] normalize(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] id;
    logic         zseen;
    id    = {hi, lo};
    zseen = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (id[127 - 8*k -: 8] == 8'd0) begin
        zseen = 1'b1;
      end
      if (zseen) begin
        id[127 - 8*k -: 8] = 8'd0;
      end
    end
    return id;
  endfunction

  state_t state;

  logic [31:0] ttl;
  logic [1:0]  op;
  logic [7:0]  service;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [31:0] now;

  logic [IDX_W-1:0] scan_idx;
  logic             issue;
  logic             rd_en;
  logic             rd_vld;
  logic             rd_last;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;

  entry_t mem [ENTRIES];
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  scan_ctl_t        ctl;
  scan_flags_t      flags;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] oldest_idx;
  logic [IDX_W-1:0] put_idx;
  entry_t           match_entry;

  logic [31:0] age;
  logic        expired;
  logic        res_hit;
  logic [63:0] res_high;
  logic [63:0] res_low;
  logic        accept;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign rd_en     = (state == ST_SCAN) && issue;

  assign ctl.start = accept;
  assign ctl.step  = rd_vld;

  assign age     = now - match_entry.stamp;
  assign expired = age > ttl;
  assign put_idx = flags.match_found ? match_idx :
                   flags.free_found  ? free_idx  : oldest_idx;

  sktab_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .idx         (rd_idx),
    .entry       (rd_data),
    .service     (service),
    .key_high    (key_high),
    .key_low     (key_low),
    .flags       (flags),
    .match_idx   (match_idx),
    .free_idx    (free_idx),
    .oldest_idx  (oldest_idx),
    .match_entry (match_entry)
  );

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = scan_idx;
    wdata = '0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (state == ST_CHECK) begin
      case (op)
        OP_PUT: begin
          we              = 1'b1;
          waddr           = put_idx;
          wdata.valid     = (key_high[63:56] != 8'd0);
          wdata.stamp     = now;
          wdata.service   = service;
          wdata.key_high  = key_high;
          wdata.key_low   = key_low;
          wdata.addr_high = addr_high;
          wdata.addr_low  = addr_low;
        end
        OP_GET: begin
          we    = flags.match_found && expired;
          waddr = match_idx;
        end
        OP_DEL: begin
          we    = flags.match_found;
          waddr = match_idx;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_idx];
    end
    rd_idx  <= scan_idx;
    rd_last <= (scan_idx == LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ttl <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op                  <= s_tuser;
      service             <= s_tdata[7:0];
      {key_high, key_low} <= normalize(s_tdata[71:8], s_tdata[135:72]);
      addr_high           <= s_tdata[199:136];
      addr_low            <= s_tdata[263:200];
      now                 <= s_tdata[295:264];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      scan_idx <= '0;
      issue    <= 1'b0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (scan_idx == LAST) begin
            scan_idx <= '0;
            state    <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            scan_idx <= '0;
            issue    <= 1'b1;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
            if (scan_idx == LAST) begin
              issue <= 1'b0;
            end
          end
          if (rd_vld && rd_last) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      res_hit  <= (op == OP_GET) && flags.match_found && !expired;
      res_high <= ((op == OP_GET) && flags.match_found && !expired) ?
                  match_entry.addr_high : 64'd0;
      res_low  <= ((op == OP_GET) && flags.match_found && !expired) ?
                  match_entry.addr_low : 64'd0;
    end
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tuser <= res_hit;
      m_tdata <= {res_low, res_high};
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !we)
    else $error("table written during scan");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SCAN))
    else $error("read data outside scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside done state");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && m_tvalid && !m_tready |=> (state == ST_DONE))
    else $error("result dropped while output stalled");

endmodule

// ----- verif/tb_session_key_table_with_expiry_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_key_table_with_expiry_unit
// Self-checking bench for the session key table. Requests go in on the
// slave stream and replies come out on the master stream. A shadow copy of
// the table and of ttl_seconds works out every reply, and the replies are
// compared in order as they arrive. Directed tests cover put/get/delete,
// id trimming at the first zero byte, empty ids, the unused opcode, expiry
// at the ttl boundary, time wrap and ttl extremes. Random traffic then fills
// the table past capacity to force oldest-entry replacement and mixes
// operations on a small key pool under several ttl settings. Both streams
// idle and stall at random, except in the closing phase.
// ----------------------------------------------------------------------------
module tb_session_key_table_with_expiry_unit;
  import sktab_pkg::*;

  localparam int ENTRIES = 128;
  localparam int POOL = 24;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } response_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // service, sid_high, sid_low, addr_high, addr_low, now
  logic [1:0]       s_tuser = '0;   // operation
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // found_addr_high, found_addr_low
  logic             m_tuser;        // hit
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [31:0]      cfg_data = '0;

  entry_t      sess_tab [ENTRIES];
  logic [31:0] ttl_s;
  logic [31:0] now_s;
  response_t   response_q [$];
  logic [7:0]   pool_svc [POOL];
  logic [127:0] pool_sid [POOL];

  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int n_fail = 0;
  int n_sent = 0;
  int n_hits = 0;
  int n_evict = 0;
  int n_cfg = 0;

  session_key_table_with_expiry_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // id ends at its first zero byte
  function automatic logic [127:0] trim_sid(input logic [127:0] sid);
    logic [127:0] id;
    logic cut;
    id = sid;
    cut = 1'b0;
    for (int b = 15; b >= 0; b--) begin
      if (id[8*b +: 8] == 8'h00) cut = 1'b1;
      if (cut) id[8*b +: 8] = 8'h00;
    end
    return id;
  endfunction

  // same trimmed id, random bytes after the terminator
  function automatic logic [127:0] scramble_tail(input logic [127:0] sid);
    logic [127:0] id;
    logic cut;
    id = sid;
    cut = 1'b0;
    for (int b = 15; b >= 0; b--) begin
      if (cut) id[8*b +: 8] = 8'($urandom());
      else if (sid[8*b +: 8] == 8'h00) cut = 1'b1;
    end
    return id;
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // non-empty id, sometimes cut short by a zero byte
  function automatic logic [127:0] make_sid();
    logic [127:0] id;
    int p;
    id = rand128();
    for (int b = 0; b < 16; b++) begin
      if (id[8*b +: 8] == 8'h00) id[8*b +: 8] = 8'h5A;
    end
    if ($urandom_range(0, 2) == 0) begin
      p = $urandom_range(0, 14);
      id[8*p +: 8] = 8'h00;
    end
    return id;
  endfunction

  function automatic response_t session_op(input logic [1:0] op, input logic [7:0] svc,
                                           input logic [127:0] sid, input logic [127:0] addr,
                                           input logic [31:0] tnow);
    response_t r;
    logic [127:0] id;
    logic [31:0] age;
    int hit_idx;
    int slot;
    int old;
    r = '0;
    id = trim_sid(sid);
    hit_idx = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (sess_tab[i].valid && sess_tab[i].service == svc &&
          {sess_tab[i].key_high, sess_tab[i].key_low} == id) hit_idx = i;
    end
    case (op)
      OP_PUT: begin
        slot = hit_idx;
        if (slot < 0) begin
          old = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !sess_tab[i].valid) slot = i;
            if (sess_tab[i].stamp < sess_tab[old].stamp) old = i;
          end
          if (slot < 0) begin
            slot = old;
            n_evict++;
          end
        end
        sess_tab[slot].valid = (id[127:120] != 8'h00);
        sess_tab[slot].stamp = tnow;
        sess_tab[slot].service = svc;
        sess_tab[slot].key_high = id[127:64];
        sess_tab[slot].key_low = id[63:0];
        sess_tab[slot].addr_high = addr[127:64];
        sess_tab[slot].addr_low = addr[63:0];
      end
      OP_GET: begin
        if (hit_idx >= 0) begin
          age = tnow - sess_tab[hit_idx].stamp;
          if (age > ttl_s) begin
            sess_tab[hit_idx].valid = 1'b0;
          end else begin
            r.hit = 1'b1;
            r.addr_high = sess_tab[hit_idx].addr_high;
            r.addr_low = sess_tab[hit_idx].addr_low;
            n_hits++;
          end
        end
      end
      OP_DEL: begin
        if (hit_idx >= 0) sess_tab[hit_idx].valid = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic send_req(input logic [1:0] op, input logic [7:0] svc,
                          input logic [127:0] sid, input logic [127:0] addr,
                          input logic [31:0] tnow);
    if (!calm && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (response_q.size() != 0) @(posedge clk);
      end
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {tnow, addr[63:0], addr[127:64], sid[63:0], sid[127:64], svc};
    do @(posedge clk); while (!s_tready);
    response_q.push_back(session_op(op, svc, sid, addr, tnow));
    n_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_ttl(input logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ttl_s = value;
    n_cfg++;
  endtask

  task automatic test_basic_ops();
    logic [127:0] k_cut;
    logic [127:0] k_low0;
    logic [127:0] k_empty;
    logic [127:0] a1;
    k_cut = {64'h0100_ABCD_EF12_3456, $urandom(), $urandom()};
    k_low0 = {64'hFFEE_DDCC_BBAA_9988, 64'h7766_5500_1122_3344};
    k_empty = {8'h00, 120'(rand128())};
    a1 = rand128();
    send_req(OP_GET, 8'h00, '0, '0, now_s);
    send_req(OP_PUT, 8'hFF, '1, '1, now_s);
    send_req(OP_GET, 8'hFF, '1, '0, now_s);
    send_req(OP_PUT, 8'h00, k_cut, '0, now_s);
    send_req(OP_GET, 8'h00, scramble_tail(k_cut), '1, now_s);
    send_req(OP_GET, 8'h01, k_cut, '0, now_s);
    send_req(OP_PUT, 8'h7E, k_low0, a1, now_s);
    send_req(OP_GET, 8'h7E, scramble_tail(k_low0), '0, now_s);
    send_req(OP_PUT, 8'hFF, '1, rand128(), now_s);
    send_req(OP_GET, 8'hFF, '1, '0, now_s);
    send_req(OP_DEL, 8'hFF, '1, '0, now_s);
    send_req(OP_GET, 8'hFF, '1, '0, now_s);
    send_req(OP_DEL, 8'hFF, '1, '0, now_s);
    // empty id is written but never found
    send_req(OP_PUT, 8'h33, k_empty, rand128(), now_s);
    send_req(OP_GET, 8'h33, k_empty, '0, now_s);
    send_req(OP_NONE, 8'h7E, scramble_tail(k_low0), rand128(), now_s);
    send_req(OP_GET, 8'h7E, k_low0, '0, now_s);
    settle();
  endtask

  task automatic test_expiry();
    logic [127:0] k;
    k = make_sid();
    now_s = now_s + 32'd10;
    send_req(OP_PUT, 8'h42, k, rand128(), now_s);
    send_req(OP_GET, 8'h42, k, '0, now_s + ttl_s);
    send_req(OP_GET, 8'h42, k, '0, now_s + ttl_s + 32'd1);
    // time wraps through zero
    send_req(OP_PUT, 8'hA5, k, rand128(), 32'hFFFF_FFFF);
    send_req(OP_GET, 8'hA5, k, '0, 32'h0000_0E0F);
    send_req(OP_GET, 8'hA5, k, '0, 32'h0000_0E10);
    now_s = 32'h0000_1000;
    settle();
  endtask

  task automatic test_ttl_extremes();
    logic [127:0] k;
    k = make_sid();
    set_ttl(32'd0);
    send_req(OP_PUT, 8'h5C, k, rand128(), now_s);
    send_req(OP_GET, 8'h5C, k, '0, now_s);
    send_req(OP_GET, 8'h5C, k, '0, now_s + 32'd1);
    set_ttl(32'hFFFF_FFFF);
    send_req(OP_PUT, 8'h5C, k, rand128(), now_s + 32'd1);
    send_req(OP_GET, 8'h5C, k, '0, now_s);
    now_s = now_s + 32'd2;
    settle();
  endtask

  task automatic test_eviction();
    logic [7:0]   fill_svc [$];
    logic [127:0] fill_sid [$];
    int k;
    set_ttl($urandom_range(100000, 1000000));
    for (int i = 0; i < ENTRIES + 12; i++) begin
      fill_svc.push_back(8'($urandom()));
      fill_sid.push_back(make_sid());
      now_s = now_s + $urandom_range(0, 1);
      send_req(OP_PUT, fill_svc[i], fill_sid[i], rand128(), now_s);
    end
    for (int i = 0; i < 30; i++) begin
      k = $urandom_range(0, fill_sid.size() - 1);
      send_req(OP_GET, fill_svc[k], scramble_tail(fill_sid[k]), rand128(), now_s);
    end
    settle();
  endtask

  task automatic test_random_traffic(input int count, input int max_step);
    int pick;
    int k;
    for (int i = 0; i < POOL; i++) begin
      pool_svc[i] = 8'($urandom());
      pool_sid[i] = make_sid();
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, POOL - 1);
      now_s = now_s + $urandom_range(0, max_step);
      if (pick < 35)
        send_req(OP_PUT, pool_svc[k], pool_sid[k], rand128(), now_s);
      else if (pick < 75)
        send_req(OP_GET, pool_svc[k], scramble_tail(pool_sid[k]), rand128(), now_s);
      else if (pick < 87)
        send_req(OP_DEL, pool_svc[k], scramble_tail(pool_sid[k]), rand128(), now_s);
      else if (pick < 91)
        send_req(OP_NONE, 8'($urandom()), rand128(), rand128(), now_s);
      else if (pick < 95)
        send_req(OP_PUT, pool_svc[k], {8'h00, 120'(rand128())}, rand128(), now_s);
      else
        send_req(OP_GET, 8'($urandom()), make_sid(), rand128(), now_s);
    end
    settle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_responses
    response_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (response_q.size() == 0) begin
        report_mismatch("reply with nothing pending", m_tdata[63:0], '0);
      end else begin
        want = response_q.pop_front();
        if (m_tuser !== want.hit) report_mismatch("hit", 64'(m_tuser), 64'(want.hit));
        if (m_tdata[63:0] !== want.addr_high)
          report_mismatch("found_addr_high", m_tdata[63:0], want.addr_high);
        if (m_tdata[127:64] !== want.addr_low)
          report_mismatch("found_addr_low", m_tdata[127:64], want.addr_low);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) sess_tab[i] = '0;
    ttl_s = TTL_RESET;
    now_s = 32'd1000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_expiry();
    test_ttl_extremes();
    test_eviction();
    set_ttl($urandom_range(20, 200));
    test_random_traffic(80, 30);
    set_ttl($urandom_range(1, 8));
    test_random_traffic(80, 4);
    calm = 1'b1;
    set_ttl(TTL_RESET);
    test_random_traffic(80, 60);
    settle();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("covered %0d requests with %0d lookup hits and %0d oldest-entry replacements",
             n_sent, n_hits, n_evict);
    $display("ttl register rewritten %0d times, %0d mismatches", n_cfg, n_fail);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
